// ===== rtl/core/acquisition_trigger_sequencer_core_defines.svh =====
// Assertion macros for the sequencer checker.
`ifndef ACQUISITION_TRIGGER_SEQUENCER_CORE_DEFINES_SVH
`define ACQUISITION_TRIGGER_SEQUENCER_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define ATS_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ATS_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/ats_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ats_pkg;

   localparam int NUM_LASERS  = 2;
   localparam int LASER_IDX_W = (NUM_LASERS > 1) ? $clog2(NUM_LASERS) : 1;
   localparam int LASER_CNT_W = LASER_IDX_W + 1;

   localparam int EXPOSURE_W = 26;
   localparam int PULSE_W    = 16;
   localparam int SETTLE_W   = 24;
   localparam int FRAME_W    = 16;
   localparam int POLL_W     = 16;
   localparam int TIMER_W    = 26;
   localparam int LINES_W    = 2;
   localparam int STATUS_W   = 2;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [EXPOSURE_W-1:0] EXPOSURE_RESET = EXPOSURE_W'(300000);
   localparam logic [PULSE_W-1:0]    PULSE_RESET    = PULSE_W'(2000);
   localparam logic [SETTLE_W-1:0]   SETTLE_RESET   = SETTLE_W'(200000);
   localparam logic [FRAME_W-1:0]    FRAMES_RESET   = FRAME_W'(2000);
   localparam logic [POLL_W-1:0]     POLL_RESET     = POLL_W'(1000);

   localparam logic [STATUS_W-1:0] STATUS_NONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_TOGGLED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ABORTED = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd3;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_EXP_A  = 3'd1,
      PH_EXP_B  = 3'd2,
      PH_GAP    = 3'd3,
      PH_PULSE  = 3'd4,
      PH_WAIT   = 3'd5,
      PH_SETTLE = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      CSR_EXPOSURE      = 3'd0,
      CSR_STAGE_PULSE   = 3'd1,
      CSR_SETTLE        = 3'd2,
      CSR_FRAME_COUNT   = 3'd3,
      CSR_POLL_INTERVAL = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [EXPOSURE_W-1:0] exposure_us;
      logic [PULSE_W-1:0]    stage_pulse_us;
      logic [SETTLE_W-1:0]   settle_us;
      logic [FRAME_W-1:0]    frame_count;
      logic [POLL_W-1:0]     poll_interval_us;
   } cfg_type;

   typedef struct packed {
      logic button_level;
      logic camera_active;
      logic stage_busy;
   } item_type;

   typedef struct packed {
      logic [LINES_W-1:0]  laser_lines;
      logic                camera_trigger;
      logic                indicator_led;
      logic                stage_trigger;
      logic [STATUS_W-1:0] status_event;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/core/ats_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ats_csr import ats_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   cfg_type             cfg_ff, cfg_in;
   logic                write_en;
   logic [2:0]          reg_index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_index)
            CSR_EXPOSURE:      cfg_in.exposure_us      = csr_pwdata[EXPOSURE_W-1:0];
            CSR_STAGE_PULSE:   cfg_in.stage_pulse_us   = csr_pwdata[PULSE_W-1:0];
            CSR_SETTLE:        cfg_in.settle_us        = csr_pwdata[SETTLE_W-1:0];
            CSR_FRAME_COUNT:   cfg_in.frame_count      = csr_pwdata[FRAME_W-1:0];
            CSR_POLL_INTERVAL: cfg_in.poll_interval_us = csr_pwdata[POLL_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         CSR_EXPOSURE:      csr_prdata = CSR_DATA_W'(cfg_ff.exposure_us);
         CSR_STAGE_PULSE:   csr_prdata = CSR_DATA_W'(cfg_ff.stage_pulse_us);
         CSR_SETTLE:        csr_prdata = CSR_DATA_W'(cfg_ff.settle_us);
         CSR_FRAME_COUNT:   csr_prdata = CSR_DATA_W'(cfg_ff.frame_count);
         CSR_POLL_INTERVAL: csr_prdata = CSR_DATA_W'(cfg_ff.poll_interval_us);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.exposure_us      <= EXPOSURE_RESET;
         cfg_ff.stage_pulse_us   <= PULSE_RESET;
         cfg_ff.settle_us        <= SETTLE_RESET;
         cfg_ff.frame_count      <= FRAMES_RESET;
         cfg_ff.poll_interval_us <= POLL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ats_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ats_engine import ats_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     step,
   input  item_type      item,
   input  cfg_type       cfg,
   output result_type    result
);

   phase_type               phase_ff, phase_in;
   logic [TIMER_W-1:0]      timer_ff, timer_in;
   logic [FRAME_W-1:0]      frame_ff, frame_in;
   logic [LASER_IDX_W-1:0]  laser_ff, laser_in;
   logic                    last_btn_ff, last_btn_in;
   logic                    run_ff, run_in;
   logic [POLL_W-1:0]       poll_ff, poll_in;

   logic [TIMER_W:0]        timer_inc;
   logic [TIMER_W-1:0]      timer_limit;
   logic                    timer_done;
   logic [FRAME_W-1:0]      frame_next;
   logic                    frame_last;
   logic [POLL_W:0]         poll_elapsed;
   logic                    poll_due;
   logic                    btn_changed;
   logic                    laser_more;
   logic                    settle_zero;
   logic                    frames_zero;
   logic                    exposing;

   // Shared conditions for the next-state and output decoders
   assign timer_inc    = {1'b0, timer_ff} + 1'b1;
   assign timer_done   = timer_inc >= {1'b0, timer_limit};
   assign frame_next   = frame_ff + 1'b1;
   assign frame_last   = frame_next >= cfg.frame_count;
   assign poll_elapsed = {1'b0, poll_ff} + 1'b1;
   assign poll_due     = poll_elapsed >= {1'b0, cfg.poll_interval_us};
   assign btn_changed  = item.button_level != last_btn_ff;
   assign laser_more   = ({1'b0, laser_ff} + 1'b1) < LASER_CNT_W'(NUM_LASERS);
   assign settle_zero  = cfg.settle_us == '0;
   assign frames_zero  = cfg.frame_count == '0;

   always_comb begin
      unique case (phase_ff)
         PH_EXP_A, PH_EXP_B: timer_limit = cfg.exposure_us >> 1;
         PH_PULSE:           timer_limit = TIMER_W'(cfg.stage_pulse_us);
         PH_SETTLE:          timer_limit = TIMER_W'(cfg.settle_us);
         default:            timer_limit = '0;
      endcase
   end

   // Next state
   always_comb begin
      phase_in    = phase_ff;
      timer_in    = timer_ff;
      frame_in    = frame_ff;
      laser_in    = laser_ff;
      last_btn_in = last_btn_ff;
      run_in      = run_ff;
      poll_in     = poll_ff;
      unique case (phase_ff)
         PH_EXP_A: begin
            timer_in = timer_inc[TIMER_W-1:0];
            if (timer_done) begin
               timer_in = '0;
               if (item.camera_active) begin
                  phase_in = PH_EXP_B;
               end else begin
                  // camera abort ends the whole run
                  phase_in = PH_IDLE;
                  run_in   = 1'b0;
                  poll_in  = '1;
               end
            end
         end
         PH_EXP_B: begin
            timer_in = timer_inc[TIMER_W-1:0];
            if (timer_done) begin
               timer_in = '0;
               phase_in = PH_GAP;
            end
         end
         PH_GAP: begin
            timer_in = '0;
            if (laser_more) begin
               laser_in = laser_ff + 1'b1;
               phase_in = PH_EXP_A;
            end else begin
               phase_in = PH_PULSE;
            end
         end
         PH_PULSE: begin
            timer_in = timer_inc[TIMER_W-1:0];
            if (timer_done) begin
               timer_in = '0;
               phase_in = PH_WAIT;
            end
         end
         PH_WAIT: begin
            if (!item.stage_busy) begin
               timer_in = '0;
               phase_in = PH_SETTLE;
               if (settle_zero) begin
                  frame_in = frame_next;
                  laser_in = '0;
                  phase_in = PH_EXP_A;
                  if (frame_last) begin
                     phase_in = PH_IDLE;
                     run_in   = 1'b0;
                     poll_in  = '1;
                  end
               end
            end
         end
         PH_SETTLE: begin
            timer_in = timer_inc[TIMER_W-1:0];
            if (timer_done) begin
               timer_in = '0;
               frame_in = frame_next;
               laser_in = '0;
               phase_in = PH_EXP_A;
               if (frame_last) begin
                  phase_in = PH_IDLE;
                  run_in   = 1'b0;
                  poll_in  = '1;
               end
            end
         end
         default: begin
            // idle polling; unknown codes fall back here
            phase_in = PH_IDLE;
            if (!poll_due) begin
               poll_in = poll_elapsed[POLL_W-1:0];
            end else begin
               poll_in = '0;
               if (btn_changed) begin
                  if (!item.button_level) begin
                     run_in = !run_ff;
                  end
                  last_btn_in = item.button_level;
               end else if (run_ff) begin
                  frame_in = '0;
                  timer_in = '0;
                  if (frames_zero) begin
                     run_in  = 1'b0;
                     poll_in = '1;
                  end else begin
                     laser_in = '0;
                     phase_in = PH_EXP_A;
                  end
               end
            end
         end
      endcase
   end

   // Outputs: line levels after the tick, event of this tick
   always_comb begin
      exposing = (phase_in == PH_EXP_A) || (phase_in == PH_EXP_B);
      for (int i = 0; i < LINES_W; i++) begin
         result.laser_lines[i] = exposing && (LASER_CNT_W'(laser_in) == LASER_CNT_W'(i));
      end
      result.camera_trigger = exposing;
      result.indicator_led  = exposing;
      result.stage_trigger  = phase_in == PH_PULSE;
      result.status_event   = STATUS_NONE;
      unique case (phase_ff)
         PH_EXP_A: begin
            if (timer_done && !item.camera_active) begin
               result.status_event = STATUS_ABORTED;
            end
         end
         PH_EXP_B, PH_GAP, PH_PULSE: begin
            result.status_event = STATUS_NONE;
         end
         PH_WAIT: begin
            if (!item.stage_busy && settle_zero && frame_last) begin
               result.status_event = STATUS_DONE;
            end
         end
         PH_SETTLE: begin
            if (timer_done && frame_last) begin
               result.status_event = STATUS_DONE;
            end
         end
         default: begin
            if (poll_due) begin
               if (btn_changed) begin
                  if (!item.button_level) begin
                     result.status_event = STATUS_TOGGLED;
                  end
               end else if (run_ff && frames_zero) begin
                  result.status_event = STATUS_DONE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         timer_ff    <= '0;
         frame_ff    <= '0;
         laser_ff    <= '0;
         last_btn_ff <= 1'b0;
         run_ff      <= 1'b0;
         poll_ff     <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         timer_ff    <= timer_in;
         frame_ff    <= frame_in;
         laser_ff    <= laser_in;
         last_btn_ff <= last_btn_in;
         run_ff      <= run_in;
         poll_ff     <= poll_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ats_rsp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ats_rsp_queue import ats_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  push,
   input  result_type push_data,
   output logic       has_room,
   output logic       rsp_valid,
   input  wire logic  rsp_ready,
   output result_type rsp_data
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = PTR_W + 1;

   result_type         entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               pop;

   assign rsp_valid = count_ff != '0;
   assign has_room  = count_ff != CNT_W'(DEPTH);
   assign rsp_data  = entries_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/acquisition_trigger_sequencer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Acquisition trigger sequencer.
// Each req_ transfer is one microsecond tick carrying the button, camera-active
// and stage-busy pin levels; each rsp_ transfer carries the laser, camera, LED
// and stage trigger levels after that tick plus a status event code.
// Exactly one result per request, in order.
// Path: a request accepted is held in the input register, processed by the
// sequencer step when the result queue has room, and offered on rsp_ from it.
// Throughput: one tick per cycle while the result queue has room, set by the
// sequencer step between the input register and the two-entry result queue.
// Stall: the result queue holds two results and the input register one more;
// req_ready drops only when all three are occupied.
// Reset (synchronous): sequencer goes to idle polling with run cleared, the
// pipeline empties and all registers but the payload and queue entries reset.
// csr_ is an APB-style port; writes are meant for idle periods only.
module acquisition_trigger_sequencer_core import ats_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_button_level,
   input  wire logic                  req_camera_active,
   input  wire logic                  req_stage_busy,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [LINES_W-1:0]    rsp_laser_lines,
   output logic                       rsp_camera_trigger,
   output logic                       rsp_indicator_led,
   output logic                       rsp_stage_trigger,
   output logic      [STATUS_W-1:0]   rsp_status_event,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   cfg_type     cfg;
   item_type    item_ff, item_in;
   logic        in_valid_ff, in_valid_in;
   logic        q_room;
   logic        step;
   result_type  step_result;
   result_type  rsp_data;

   // Advance the sequencer whenever a tick is held and the queue can take it
   assign step      = in_valid_ff && q_room;
   assign req_ready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      item_in     = item_ff;
      if (req_valid && req_ready) begin
         in_valid_in           = 1'b1;
         item_in.button_level  = req_button_level;
         item_in.camera_active = req_camera_active;
         item_in.stage_busy    = req_stage_busy;
      end else if (step) begin
         // drop the tick once it has been consumed
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Payload register: no reset needed
   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   ats_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ats_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item_ff),
      .cfg    (cfg),
      .result (step_result)
   );

   ats_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step),
      .push_data (step_result),
      .has_room  (q_room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_laser_lines    = rsp_data.laser_lines;
   assign rsp_camera_trigger = rsp_data.camera_trigger;
   assign rsp_indicator_led  = rsp_data.indicator_led;
   assign rsp_stage_trigger  = rsp_data.stage_trigger;
   assign rsp_status_event   = rsp_data.status_event;

endmodule

`default_nettype wire

// ===== rtl/core/ats_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "acquisition_trigger_sequencer_core_defines.svh"

module ats_checker import ats_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [LINES_W-1:0]  rsp_laser_lines,
   input wire logic                rsp_camera_trigger,
   input wire logic                rsp_indicator_led,
   input wire logic                rsp_stage_trigger,
   input wire logic [STATUS_W-1:0] rsp_status_event
);

   `ATS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && req_ready, "pipeline not empty after reset")
   `ATS_ASSERT(a_one_laser, clock, reset, rsp_valid |-> $onehot0(rsp_laser_lines), "more than one laser on")
   `ATS_ASSERT(a_lines_follow_camera, clock, reset, rsp_valid |-> (rsp_indicator_led == rsp_camera_trigger) && (rsp_camera_trigger || rsp_laser_lines == '0) && !(rsp_camera_trigger && rsp_stage_trigger), "laser, LED and stage levels disagree with camera trigger")
   `ATS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_laser_lines) && $stable(rsp_camera_trigger) && $stable(rsp_stage_trigger) && $stable(rsp_status_event), "stalled result changed")

endmodule

bind acquisition_trigger_sequencer_core ats_checker u_ats_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_laser_lines    (rsp_laser_lines),
   .rsp_camera_trigger (rsp_camera_trigger),
   .rsp_indicator_led  (rsp_indicator_led),
   .rsp_stage_trigger  (rsp_stage_trigger),
   .rsp_status_event   (rsp_status_event)
);

`default_nettype wire
